### hdl/wmsc_pkg.sv
// ----------------------------------------------------------------------------
// wmsc_pkg
// Shared types and constants for the module stream checker.
// ----------------------------------------------------------------------------
`default_nettype none
package wmsc_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  error_code;
    logic [3:0]  section_id;
    logic [1:0]  import_event;
    logic [31:0] value_first;
    logic [31:0] value_second;
  } out_beat_t;

  localparam logic [3:0] ErrNone     = 4'd0;
  localparam logic [3:0] ErrEarlyEnd = 4'd1;
  localparam logic [3:0] ErrMagic    = 4'd2;
  localparam logic [3:0] ErrVersion  = 4'd3;
  localparam logic [3:0] ErrSecId    = 4'd4;
  localparam logic [3:0] ErrLeb      = 4'd5;
  localparam logic [3:0] ErrName     = 4'd6;
  localparam logic [3:0] ErrKind     = 4'd7;
  localparam logic [3:0] ErrMemtype  = 4'd8;
  localparam logic [3:0] ErrOverrun  = 4'd10;

  localparam logic [1:0] StParsing  = 2'd0;
  localparam logic [1:0] StAccepted = 2'd1;
  localparam logic [1:0] StError    = 2'd2;

  localparam logic [1:0] EvNone = 2'd0;
  localparam logic [1:0] EvFunc = 2'd1;
  localparam logic [1:0] EvMem  = 2'd2;

  localparam logic [7:0] SharedMemtype = 8'h03;
  localparam logic [7:0] KindFunc      = 8'h00;
  localparam logic [7:0] KindMem       = 8'h02;
  localparam logic [3:0] ImportSection = 4'd2;
  localparam logic [7:0] MaxSectionId  = 8'd12;

  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    unique case (idx)
      3'd0: header_byte = 8'h00;
      3'd1: header_byte = 8'h61;
      3'd2: header_byte = 8'h73;
      3'd3: header_byte = 8'h6D;
      3'd4: header_byte = 8'h01;
      default: header_byte = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

### hdl/wmsc_stream_if.sv
// ----------------------------------------------------------------------------
// wmsc_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface wmsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/wmsc_front.sv
// ----------------------------------------------------------------------------
// wmsc_front
// Input register and small queue; decouples byte intake from the parser.
// ----------------------------------------------------------------------------
`default_nettype none
module wmsc_front #(
  parameter int unsigned DEPTH = wmsc_pkg::QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire wmsc_pkg::in_beat_t in_beat,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output wmsc_pkg::in_beat_t   q_beat
);
  import wmsc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  in_beat_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            push;
  logic            pop;

  assign in_ready = (count != (AW+1)'(DEPTH)) || pop;
  assign q_valid  = (count != '0);
  assign q_beat   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_beat;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/wmsc_back.sv
// ----------------------------------------------------------------------------
// wmsc_back
// Byte parser: header, section framing, LEB128 and import entries.
// ----------------------------------------------------------------------------
`default_nettype none
module wmsc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire wmsc_pkg::in_beat_t q_beat,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wmsc_pkg::out_beat_t   out_beat
);
  import wmsc_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER, PH_SEC_ID, PH_SEC_SIZE, PH_SKIP, PH_VEC, PH_MODLEN, PH_MODBYTES,
    PH_FLDLEN, PH_FLDBYTES, PH_KIND, PH_TYPEIDX, PH_MEMTYPE, PH_MEMMIN, PH_MEMMAX
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  hdr_cnt, hdr_cnt_next;
  logic [3:0]  cur_sec, cur_sec_next;
  logic [31:0] sec_left, sec_left_next;
  logic [31:0] leb_val, leb_val_next;
  logic [2:0]  leb_cnt, leb_cnt_next;
  logic [31:0] name_left, name_left_next;
  logic [31:0] imp_left, imp_left_next;
  logic [31:0] saved_min, saved_min_next;
  logic [3:0]  err, err_next;

  logic        fire;
  logic [7:0]  b;
  logic        leb_bad, leb_done;
  logic [31:0] leb_full;
  logic [2:0]  n;
  logic [1:0]  ev;
  logic [31:0] v1, v2;
  logic [1:0]  st;
  logic [31:0] dec_left;

  // output register doubles as skid: accept whenever it is empty or draining
  assign q_ready = !out_valid || out_ready;
  assign fire    = q_valid && q_ready;
  assign b       = q_beat.data_byte;

  // leb128 step; byte index saturates at four
  always_comb begin
    n        = (leb_cnt > 3'd4) ? 3'd4 : leb_cnt;
    leb_bad  = (n == 3'd4) && (b[7:4] != 4'd0);
    leb_full = leb_val | (32'(b[6:0]) << (5'(n) * 5'd7));
    leb_done = !b[7];
  end

  always_comb begin
    phase_next     = phase;
    hdr_cnt_next   = hdr_cnt;
    cur_sec_next   = cur_sec;
    sec_left_next  = sec_left;
    leb_val_next   = leb_val;
    leb_cnt_next   = leb_cnt;
    name_left_next = name_left;
    imp_left_next  = imp_left;
    saved_min_next = saved_min;
    err_next       = err;
    ev = EvNone;
    v1 = '0;
    v2 = '0;
    st = StParsing;
    dec_left  = (sec_left != '0) ? sec_left - 32'd1 : sec_left;

    if (err == ErrNone) begin
      unique case (phase)
        PH_HEADER: begin
          if (b != header_byte(hdr_cnt)) begin
            err_next = hdr_cnt[2] ? ErrVersion : ErrMagic;
          end else if (hdr_cnt == 3'd7) begin
            hdr_cnt_next = '0;
            phase_next   = PH_SEC_ID;
          end else begin
            hdr_cnt_next = hdr_cnt + 3'd1;
          end
        end
        PH_SEC_ID: begin
          if (b > MaxSectionId) begin
            err_next = ErrSecId;
          end else begin
            cur_sec_next = b[3:0];
            leb_val_next = '0;
            leb_cnt_next = '0;
            phase_next   = PH_SEC_SIZE;
          end
        end
        PH_SEC_SIZE: begin
          if (leb_bad) begin
            err_next = ErrLeb;
          end else if (leb_done) begin
            sec_left_next = leb_full;
            leb_val_next  = '0;
            leb_cnt_next  = '0;
            if (leb_full == '0) phase_next = PH_SEC_ID;
            else phase_next = (cur_sec == ImportSection) ? PH_VEC : PH_SKIP;
          end else begin
            leb_val_next = leb_full;
            leb_cnt_next = n + 3'd1;
          end
        end
        PH_SKIP: begin
          sec_left_next = dec_left;
          if (dec_left == '0) phase_next = PH_SEC_ID;
        end
        default: begin
          sec_left_next = dec_left;
          unique case (phase)
            PH_MODBYTES, PH_FLDBYTES: begin
              name_left_next = (name_left != '0) ? name_left - 32'd1 : name_left;
              if (name_left_next == '0) begin
                phase_next = (phase == PH_MODBYTES) ? PH_FLDLEN : PH_KIND;
              end
            end
            PH_KIND: begin
              leb_val_next = '0;
              leb_cnt_next = '0;
              if (b == KindFunc) phase_next = PH_TYPEIDX;
              else if (b == KindMem) phase_next = PH_MEMTYPE;
              else err_next = ErrKind;
            end
            PH_MEMTYPE: begin
              leb_val_next = '0;
              leb_cnt_next = '0;
              if (b == SharedMemtype) phase_next = PH_MEMMIN;
              else err_next = ErrMemtype;
            end
            default: begin
              if (leb_bad) begin
                err_next = ErrLeb;
              end else if (!leb_done) begin
                leb_val_next = leb_full;
                leb_cnt_next = n + 3'd1;
              end else begin
                leb_val_next = '0;
                leb_cnt_next = '0;
                unique case (phase)
                  PH_VEC: begin
                    imp_left_next = leb_full;
                    phase_next    = (leb_full != '0) ? PH_MODLEN : PH_VEC;
                  end
                  PH_MODLEN, PH_FLDLEN: begin
                    if (leb_full > dec_left) begin
                      err_next     = ErrName;
                      leb_val_next = leb_val;
                      leb_cnt_next = leb_cnt;
                    end else begin
                      name_left_next = leb_full;
                      if (leb_full != '0) begin
                        phase_next = (phase == PH_MODLEN) ? PH_MODBYTES : PH_FLDBYTES;
                      end else begin
                        phase_next = (phase == PH_MODLEN) ? PH_FLDLEN : PH_KIND;
                      end
                    end
                  end
                  PH_MEMMIN: begin
                    saved_min_next = leb_full;
                    phase_next     = PH_MEMMAX;
                  end
                  default: begin
                    // type index or memory maximum closes the entry
                    ev = (phase == PH_TYPEIDX) ? EvFunc : EvMem;
                    v1 = (phase == PH_TYPEIDX) ? leb_full : saved_min;
                    v2 = (phase == PH_TYPEIDX) ? '0 : leb_full;
                    imp_left_next = (imp_left != '0) ? imp_left - 32'd1 : imp_left;
                    phase_next = (imp_left_next != '0) ? PH_MODLEN : PH_VEC;
                  end
                endcase
              end
            end
          endcase
          // section ran out inside the import vector
          if (err_next == ErrNone && dec_left == '0) begin
            if (phase_next == PH_VEC && leb_cnt_next == '0) phase_next = PH_SEC_ID;
            else if (phase_next == PH_KIND) err_next = ErrKind;
            else if (phase_next == PH_MEMTYPE) err_next = ErrMemtype;
            else if (phase_next == PH_MODBYTES || phase_next == PH_FLDBYTES)
              err_next = ErrName;
            else err_next = ErrLeb;
          end
        end
      endcase
    end

    if (err_next != ErrNone) begin
      st = StError;
    end else if (q_beat.last) begin
      if (phase_next == PH_SEC_ID) begin
        st = StAccepted;
      end else begin
        err_next = (phase_next == PH_HEADER || phase_next == PH_SEC_SIZE) ?
                   ErrEarlyEnd : ErrOverrun;
        st = StError;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_beat.status       <= st;
      out_beat.error_code   <= err_next;
      out_beat.section_id   <= cur_sec_next;
      out_beat.import_event <= ev;
      out_beat.value_first  <= v1;
      out_beat.value_second <= v2;
    end
    if (rst || (fire && q_beat.last)) begin
      phase     <= PH_HEADER;
      hdr_cnt   <= '0;
      cur_sec   <= '0;
      sec_left  <= '0;
      leb_val   <= '0;
      leb_cnt   <= '0;
      name_left <= '0;
      imp_left  <= '0;
      saved_min <= '0;
      err       <= ErrNone;
    end else if (fire) begin
      phase     <= phase_next;
      hdr_cnt   <= hdr_cnt_next;
      cur_sec   <= cur_sec_next;
      sec_left  <= sec_left_next;
      leb_val   <= leb_val_next;
      leb_cnt   <= leb_cnt_next;
      name_left <= name_left_next;
      imp_left  <= imp_left_next;
      saved_min <= saved_min_next;
      err       <= err_next;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### hdl/wasm_module_stream_checker_core.sv
// ----------------------------------------------------------------------------
// wasm_module_stream_checker_core
// Byte-stream checker for module images: header, sections and imports.
// ----------------------------------------------------------------------------
// path: an accepted byte beat is stored in the queue, then parsed into the registered result beat
// throughput: one byte beat per cycle while out_ready is not holding the output, set by the parser step
// reset: synchronous rst clears queue, parser state and output valid
// the parser also returns to its reset state after each beat marked last
`default_nettype none
module wasm_module_stream_checker_core #(
  parameter int unsigned QUEUE_DEPTH = wmsc_pkg::QueueDepth
) (
  input wire logic clk,
  input wire logic rst,
  wmsc_stream_if.sink   in_ch,
  wmsc_stream_if.source out_ch
);
  import wmsc_pkg::*;

  logic     q_valid;
  logic     q_ready;
  in_beat_t q_beat;

  wmsc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_beat  (in_ch.payload),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_beat   (q_beat)
  );

  wmsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_beat    (q_beat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_beat  (out_ch.payload)
  );
endmodule
`default_nettype wire

### sim/tb_wasm_module_stream_checker_core.sv
// ----------------------------------------------------------------------------
// tb_wasm_module_stream_checker_core
// Sends module images byte by byte and compares every result beat against
// a behavioral parser model kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_wasm_module_stream_checker_core;
  import wmsc_pkg::*;

  typedef enum logic [4:0] {
    PhHeader, PhSecId, PhSecSize, PhSkip, PhVec, PhModLen, PhModBytes,
    PhFldLen, PhFldBytes, PhKind, PhTypeIdx, PhMemtype, PhMemMin, PhMemMax
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wmsc_stream_if #(.payload_t(in_beat_t))  in_ch ();
  wmsc_stream_if #(.payload_t(out_beat_t)) out_ch ();

  wasm_module_stream_checker_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // parser model state
  phase_t      ph;
  logic [2:0]  hdr_cnt;
  logic [3:0]  cur_sec;
  logic [31:0] sec_left, leb_val, name_left, imp_left, min_pages;
  logic [2:0]  leb_cnt;
  logic [3:0]  err;

  out_beat_t expected_beats[$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_recv = 0;

  task automatic parser_reset();
    ph = PhHeader; hdr_cnt = 0; cur_sec = 0; sec_left = 0; leb_val = 0;
    leb_cnt = 0; name_left = 0; imp_left = 0; min_pages = 0; err = ErrNone;
  endtask

  // -1 malformed, 0 more bytes, 1 done
  function automatic int leb_step(input logic [7:0] b);
    logic [2:0] n;
    n = (leb_cnt > 4) ? 3'd4 : leb_cnt;
    if (n == 4 && (b & 8'hF0) != 0) return -1;
    leb_val = leb_val | (32'(b[6:0]) << (7 * n));
    if (b[7]) begin
      leb_cnt = n + 3'd1;
      return 0;
    end
    return 1;
  endfunction

  task automatic entry_finish();
    if (imp_left > 0) imp_left--;
    ph = (imp_left != 0) ? PhModLen : PhVec;
    leb_val = 0; leb_cnt = 0;
  endtask

  task automatic import_step(input logic [7:0] b, inout out_beat_t o);
    int r;
    bit is_mod;
    case (ph)
      PhVec: begin
        r = leb_step(b);
        if (r < 0) err = ErrLeb;
        else if (r > 0) begin
          imp_left = leb_val; leb_val = 0; leb_cnt = 0;
          ph = (imp_left != 0) ? PhModLen : PhVec;
        end
      end
      PhModLen, PhFldLen: begin
        r = leb_step(b);
        is_mod = (ph == PhModLen);
        if (r < 0) err = ErrLeb;
        else if (r > 0) begin
          if (leb_val > sec_left) err = ErrName;
          else begin
            name_left = leb_val; leb_val = 0; leb_cnt = 0;
            if (name_left != 0) ph = is_mod ? PhModBytes : PhFldBytes;
            else ph = is_mod ? PhFldLen : PhKind;
          end
        end
      end
      PhModBytes, PhFldBytes: begin
        if (name_left > 0) name_left--;
        if (name_left == 0) ph = (ph == PhModBytes) ? PhFldLen : PhKind;
      end
      PhKind: begin
        leb_val = 0; leb_cnt = 0;
        if (b == KindFunc) ph = PhTypeIdx;
        else if (b == KindMem) ph = PhMemtype;
        else err = ErrKind;
      end
      PhTypeIdx: begin
        r = leb_step(b);
        if (r < 0) err = ErrLeb;
        else if (r > 0) begin
          o.import_event = EvFunc; o.value_first = leb_val; entry_finish();
        end
      end
      PhMemtype: begin
        leb_val = 0; leb_cnt = 0;
        if (b == SharedMemtype) ph = PhMemMin;
        else err = ErrMemtype;
      end
      PhMemMin: begin
        r = leb_step(b);
        if (r < 0) err = ErrLeb;
        else if (r > 0) begin
          min_pages = leb_val; leb_val = 0; leb_cnt = 0; ph = PhMemMax;
        end
      end
      PhMemMax: begin
        r = leb_step(b);
        if (r < 0) err = ErrLeb;
        else if (r > 0) begin
          o.import_event = EvMem; o.value_first = min_pages;
          o.value_second = leb_val; entry_finish();
        end
      end
      default: err = ErrLeb;
    endcase
  endtask

  task automatic predict_result(input in_beat_t x);
    out_beat_t o;
    logic [7:0] b;
    logic [7:0] hdr [8];
    int r;
    hdr = '{8'h00, 8'h61, 8'h73, 8'h6D, 8'h01, 8'h00, 8'h00, 8'h00};
    o = '0;
    b = x.data_byte;
    if (err == ErrNone) begin
      case (ph)
        PhHeader: begin
          if (b != hdr[hdr_cnt]) err = (hdr_cnt < 4) ? ErrMagic : ErrVersion;
          else if (hdr_cnt == 7) begin
            hdr_cnt = 0; ph = PhSecId;
          end else hdr_cnt++;
        end
        PhSecId: begin
          if (b > MaxSectionId) err = ErrSecId;
          else begin
            cur_sec = b[3:0]; leb_val = 0; leb_cnt = 0; ph = PhSecSize;
          end
        end
        PhSecSize: begin
          r = leb_step(b);
          if (r < 0) err = ErrLeb;
          else if (r > 0) begin
            sec_left = leb_val; leb_val = 0; leb_cnt = 0;
            if (sec_left == 0) ph = PhSecId;
            else ph = (cur_sec == ImportSection) ? PhVec : PhSkip;
          end
        end
        PhSkip: begin
          if (sec_left > 0) sec_left--;
          if (sec_left == 0) ph = PhSecId;
        end
        default: begin
          if (sec_left > 0) sec_left--;
          import_step(b, o);
          if (err == ErrNone && sec_left == 0) begin
            if (ph == PhVec && leb_cnt == 0) ph = PhSecId;
            else if (ph == PhKind) err = ErrKind;
            else if (ph == PhMemtype) err = ErrMemtype;
            else if (ph == PhModBytes || ph == PhFldBytes) err = ErrName;
            else err = ErrLeb;
          end
        end
      endcase
    end
    if (err != ErrNone) o.status = StError;
    else if (x.last) begin
      if (ph == PhSecId) o.status = StAccepted;
      else begin
        err = (ph == PhHeader || ph == PhSecSize) ? ErrEarlyEnd : ErrOverrun;
        o.status = StError;
      end
    end
    o.error_code = err;
    o.section_id = cur_sec;
    expected_beats = {expected_beats, o};
    if (x.last) parser_reset();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit lst);
    in_beat_t x;
    x.data_byte = b;
    x.last = lst;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_result(x);
  endtask

  // result checker
  always @(posedge clk) begin
    out_beat_t g, e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      g = out_ch.payload;
      if (expected_beats.size() == 0) report_mismatch("unexpected beat", 0, 0);
      else begin
        e = expected_beats.pop_front();
        if (g.status != e.status)
          report_mismatch("status", 32'(g.status), 32'(e.status));
        if (g.error_code != e.error_code)
          report_mismatch("error_code", 32'(g.error_code), 32'(e.error_code));
        if (g.section_id != e.section_id)
          report_mismatch("section_id", 32'(g.section_id), 32'(e.section_id));
        if (g.import_event != e.import_event)
          report_mismatch("import_event", 32'(g.import_event), 32'(e.import_event));
        if (g.value_first != e.value_first)
          report_mismatch("value_first", g.value_first, e.value_first);
        if (g.value_second != e.value_second)
          report_mismatch("value_second", g.value_second, e.value_second);
      end
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  // byte image built up before sending
  logic [7:0] img[$];

  task automatic append_byte(input logic [7:0] v);
    img = {img, v};
  endtask

  task automatic put_leb(input logic [31:0] v);
    do begin
      append_byte({(v >> 7) != 0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endtask

  task automatic send_image();
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
    img.delete();
  endtask

  task automatic put_header();
    append_byte(8'h00); append_byte(8'h61); append_byte(8'h73);
    append_byte(8'h6D); append_byte(8'h01); append_byte(8'h00);
    append_byte(8'h00); append_byte(8'h00);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(3))
      0: return $urandom_range(127);
      1: return $urandom_range(16383);
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // random import section with optional repeated vector counts
  task automatic put_import_section();
    logic [7:0] body[$];
    logic [7:0] save[$];
    int n, vecs;
    save = img; img.delete();
    vecs = $urandom_range(1, 2);
    repeat (vecs) begin
      n = $urandom_range(0, 2);
      put_leb(n);
      repeat (n) begin
        repeat (2) begin
          int len;
          len = $urandom_range(0, 3);
          put_leb(len);
          repeat (len) append_byte(8'($urandom));
        end
        if ($urandom_range(1)) begin
          append_byte(KindFunc); put_leb(rand_val());
        end else begin
          append_byte(KindMem); append_byte(SharedMemtype);
          put_leb(rand_val()); put_leb(rand_val());
        end
      end
    end
    body = img; img = save;
    // occasional corruption of one body byte
    if ($urandom_range(9) == 0 && body.size() > 0)
      body[$urandom_range(body.size() - 1)] = 8'($urandom);
    append_byte(8'(ImportSection));
    put_leb(body.size() + (($urandom_range(14) == 0) ? -1 : 0));
    foreach (body[i]) append_byte(body[i]);
  endtask

  task automatic put_module();
    put_header();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(1)) put_import_section();
      else begin
        int len;
        append_byte(8'($urandom_range(12)));
        len = $urandom_range(0, 4);
        put_leb(len);
        repeat (len) append_byte(8'($urandom));
      end
    end
    if ($urandom_range(19) == 0) append_byte(8'($urandom));
    if ($urandom_range(19) == 0) void'(img.pop_back());
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0 && guard < 100000) begin
      @(posedge clk); guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    // accepted header only, then header faults
    put_header(); send_image();
    append_byte(8'h01); send_image();
    put_header(); img[5] = 8'hFF; send_image();
    append_byte(8'h00); append_byte(8'h61); send_image();
    // bad section id, overlong leb, section overrun
    put_header(); append_byte(8'h0D); append_byte(8'h00); send_image();
    put_header(); append_byte(8'h01);
    repeat (4) append_byte(8'hFF);
    append_byte(8'h7F); send_image();
    put_header(); append_byte(8'h00); append_byte(8'h05);
    append_byte(8'hAA); send_image();
    // import: func + mem, then bad kind, memtype, long name
    put_header(); append_byte(8'h02); append_byte(8'd13);
    append_byte(8'h02); append_byte(8'h00); append_byte(8'h00);
    append_byte(KindFunc); append_byte(8'h05);
    append_byte(8'h00); append_byte(8'h00); append_byte(KindMem);
    append_byte(SharedMemtype); append_byte(8'h01); append_byte(8'h02);
    append_byte(8'h00); append_byte(8'h00); send_image();
    put_header(); append_byte(8'h02); append_byte(8'h04);
    append_byte(8'h01); append_byte(8'h00); append_byte(8'h00);
    append_byte(8'h07); send_image();
    put_header(); append_byte(8'h02); append_byte(8'h05);
    append_byte(8'h01); append_byte(8'h00); append_byte(8'h00);
    append_byte(KindMem); append_byte(8'h01); send_image();
    put_header(); append_byte(8'h02); append_byte(8'h03);
    append_byte(8'h01); append_byte(8'h09); append_byte(8'h00);
    send_image();
    // section ends where the kind byte should be
    put_header(); append_byte(8'h02); append_byte(8'h03);
    append_byte(8'h01); append_byte(8'h00); append_byte(8'h00);
    send_image();
    wait_drained();
  endtask

  task automatic test_random(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
      end else put_module();
      if (img.size() == 0) append_byte(8'($urandom));
      sent += img.size();
      send_image();
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1;
        repeat (60) @(posedge clk);
        hold_recv = 0;
      end
    join_none
    put_module(); put_module(); send_image();
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    parser_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle = 12; recv_idle = 53;
    test_random(450);
    send_idle = 53; recv_idle = 12;
    test_random(450);
    send_idle = 0; recv_idle = 0;
    test_backpressure();
    test_random(450);
    if (mismatches == 0 && expected_beats.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

### wasm_module_stream_checker_core.f
hdl/wmsc_pkg.sv
hdl/wmsc_stream_if.sv
hdl/wmsc_front.sv
hdl/wmsc_back.sv
hdl/wasm_module_stream_checker_core.sv
sim/tb_wasm_module_stream_checker_core.sv
